// File: hdl/miq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// miq_pkg
// Shared types and constants of the multi-port instruction queue.
// ----------------------------------------------------------------------------
package miq_pkg;

  localparam int FIELD_TAGS = 2;
  localparam int CNT_W      = 2;
  localparam int FTAG_W     = 32;
  localparam int STATE_W    = 2;
  localparam int OCC_W      = 4;
  localparam int WORD_W     = 2 * CNT_W + FIELD_TAGS * FTAG_W + OCC_W;

  localparam logic [STATE_W-1:0] ST_WAITING  = 2'd0;
  localparam logic [STATE_W-1:0] ST_READY    = 2'd1;
  localparam logic [STATE_W-1:0] ST_EXECUTED = 2'd2;
  localparam logic [STATE_W-1:0] ST_NONE     = 2'd3;
  localparam logic [STATE_W-1:0] LC_RESET    = ST_READY;

  localparam logic [CNT_W-1:0] SHIFT_NONE  = 2'd0;
  localparam logic [CNT_W-1:0] SHIFT_ONE   = 2'd1;
  localparam logic [CNT_W-1:0] SHIFT_TWO   = 2'd2;
  localparam logic [CNT_W-1:0] SHIFT_THREE = 2'd3;

  typedef struct packed {
    logic             en;
    logic [CNT_W-1:0] rm;
    logic [CNT_W-1:0] ins;
  } miq_ctrl_t;

endpackage
`default_nettype wire

// File: hdl/miq_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// miq_cell
// One queue slot: holds the tag at a fixed head position, shifts toward the
// head by the removed count and loads a submitted tag when it is one of
// the free slots being filled.
// ----------------------------------------------------------------------------
module miq_cell #(
  parameter int IDX        = 0,
  parameter int DEPTH_LOG2 = 3,
  parameter int TAG_WIDTH  = 32
) (
  input  wire logic                                          clk,
  input  wire miq_pkg::miq_ctrl_t                            ctrl,
  input  wire logic [DEPTH_LOG2:0]                           base,
  input  wire logic [TAG_WIDTH-1:0]                          nbr1,
  input  wire logic [TAG_WIDTH-1:0]                          nbr2,
  input  wire logic [TAG_WIDTH-1:0]                          nbr3,
  input  wire logic [miq_pkg::FIELD_TAGS-1:0][TAG_WIDTH-1:0] sub_tags,
  output logic      [TAG_WIDTH-1:0]                          tag_r,
  output logic      [TAG_WIDTH-1:0]                          tag_nxt
);
  import miq_pkg::*;

  localparam int CW = DEPTH_LOG2 + 1;
  localparam logic [CW-1:0] IDX_C = CW'(IDX);

  logic [CW-1:0] off;
  logic          load;

  assign off  = IDX_C - base;
  assign load = (IDX_C >= base) && (off < CW'(ctrl.ins));

  always_comb begin
    tag_nxt = tag_r;
    if (ctrl.en) begin
      if (load) begin
        tag_nxt = sub_tags[off[0]];
      end else begin
        unique case (ctrl.rm)
          SHIFT_NONE:  tag_nxt = tag_r;
          SHIFT_ONE:   tag_nxt = nbr1;
          SHIFT_TWO:   tag_nxt = nbr2;
          SHIFT_THREE: tag_nxt = nbr3;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    tag_r <= tag_nxt;
  end

endmodule
`default_nettype wire

// File: hdl/multi_port_instruction_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// multi_port_instruction_queue
// Instruction tag queue built as a row of slots ordered from the head.
// ----------------------------------------------------------------------------
// Each input word is one pipeline tick: accepted count, submitted count, two
// submitted tags and the state codes of the two head positions. The queue
// first drops up to accepted_count head entries, then inserts submitted tags
// in port order until the ports run out or the queue is full, then offers
// leading head entries whose state code is at least the leave threshold.
// Each input word yields one output word: inserted count, offered count, the
// two offered tags (zero when not offered) and the occupancy.
// The word is registered on accept and appears on out_* in the next cycle.
// One word per cycle is taken while the receiver does not stall; each slot
// moves its tag zero to three positions per tick; all slots update at once.
// in_tready is high whenever the output register is empty or being taken;
// a stalled receiver holds the output word and blocks new input.
// cfg_ready is always high; write the leave threshold only while idle.
// Reset empties the queue and sets the leave threshold to ready. Slot
// contents are not cleared; only slots inside the occupancy are read.
// ----------------------------------------------------------------------------
module multi_port_instruction_queue #(
  parameter int DEPTH_LOG2  = 3,
  parameter int SUB_PORTS   = 2,
  parameter int OFFER_PORTS = 2,
  parameter int TAG_WIDTH   = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  // accepted_count[1:0], submit_count[3:2], submit_tag_first[35:4],
  // submit_tag_second[67:36], head_states[71:68]
  input  wire logic [miq_pkg::WORD_W-1:0]   in_tdata,
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  // inserted_count[1:0], offered_count[3:2], offered_tag_first[35:4],
  // offered_tag_second[67:36], occupancy[71:68]
  output logic      [miq_pkg::WORD_W-1:0]   out_tdata,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [miq_pkg::STATE_W-1:0]  cfg_data
);
  import miq_pkg::*;

  localparam int DEPTH   = 1 << DEPTH_LOG2;
  localparam int CW      = DEPTH_LOG2 + 1;
  localparam int IN_LIM  = (SUB_PORTS < FIELD_TAGS) ? SUB_PORTS : FIELD_TAGS;
  localparam int OUT_LIM = (OFFER_PORTS < FIELD_TAGS) ? OFFER_PORTS : FIELD_TAGS;

  logic                  in_fire;
  logic [CNT_W-1:0]      acc_cnt;
  logic [CNT_W-1:0]      sub_cnt;
  logic [FTAG_W-1:0]     sub_tag0;
  logic [FTAG_W-1:0]     sub_tag1;
  logic [STATE_W-1:0]    st0;
  logic [STATE_W-1:0]    st1;

  logic [STATE_W-1:0]    lc_r;
  logic [CW-1:0]         count_r;
  logic [CW-1:0]         count_nxt;
  logic [CW-1:0]         rm;
  logic [CW-1:0]         after_rm;
  logic [CW-1:0]         space;
  logic [CW-1:0]         sub_n;
  logic [CW-1:0]         ins;
  miq_ctrl_t             ctrl;

  logic [FIELD_TAGS-1:0][TAG_WIDTH-1:0] sub_tags;
  logic [DEPTH-1:0][TAG_WIDTH-1:0]      cell_tag;
  logic [DEPTH-1:0][TAG_WIDTH-1:0]      cell_nxt;
  logic [TAG_WIDTH-1:0]                 head0;
  logic [TAG_WIDTH-1:0]                 head1;

  logic                  off0;
  logic                  off1;
  logic [CNT_W-1:0]      off_cnt;

  logic                  out_valid_r;
  logic [WORD_W-1:0]     out_data_r;

  assign acc_cnt  = in_tdata[1:0];
  assign sub_cnt  = in_tdata[3:2];
  assign sub_tag0 = in_tdata[35:4];
  assign sub_tag1 = in_tdata[67:36];
  assign st0      = in_tdata[69:68];
  assign st1      = in_tdata[71:70];

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign sub_tags[0] = TAG_WIDTH'(sub_tag0);
  assign sub_tags[1] = TAG_WIDTH'(sub_tag1);

  always_comb begin
    rm        = (CW'(acc_cnt) < count_r) ? CW'(acc_cnt) : count_r;
    after_rm  = count_r - rm;
    space     = CW'(DEPTH) - after_rm;
    sub_n     = (CW'(sub_cnt) < CW'(IN_LIM)) ? CW'(sub_cnt) : CW'(IN_LIM);
    ins       = (sub_n < space) ? sub_n : space;
    count_nxt = after_rm + ins;
    ctrl.en   = in_fire;
    ctrl.rm   = CNT_W'(rm);
    ctrl.ins  = CNT_W'(ins);
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [TAG_WIDTH-1:0] n1;
    logic [TAG_WIDTH-1:0] n2;
    logic [TAG_WIDTH-1:0] n3;
    if (i + 1 < DEPTH) begin : g_n1
      assign n1 = cell_tag[i+1];
    end else begin : g_n1_end
      assign n1 = '0;
    end
    if (i + 2 < DEPTH) begin : g_n2
      assign n2 = cell_tag[i+2];
    end else begin : g_n2_end
      assign n2 = '0;
    end
    if (i + 3 < DEPTH) begin : g_n3
      assign n3 = cell_tag[i+3];
    end else begin : g_n3_end
      assign n3 = '0;
    end
    miq_cell #(
      .IDX        (i),
      .DEPTH_LOG2 (DEPTH_LOG2),
      .TAG_WIDTH  (TAG_WIDTH)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .base     (after_rm),
      .nbr1     (n1),
      .nbr2     (n2),
      .nbr3     (n3),
      .sub_tags (sub_tags),
      .tag_r    (cell_tag[i]),
      .tag_nxt  (cell_nxt[i])
    );
  end

  assign head0 = cell_nxt[0];
  if (DEPTH > 1) begin : g_head1
    assign head1 = cell_nxt[1];
  end else begin : g_head1_none
    assign head1 = '0;
  end

  assign off0    = (OUT_LIM >= 1) && (count_nxt >= CW'(1)) && (st0 >= lc_r);
  assign off1    = off0 && (OUT_LIM >= 2) && (count_nxt >= CW'(2)) && (st1 >= lc_r);
  assign off_cnt = CNT_W'({1'b0, off0} + {1'b0, off1});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lc_r        <= LC_RESET;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        lc_r <= cfg_data;
      end
      if (in_fire) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= {OCC_W'(count_nxt),
                     off1 ? FTAG_W'(head1) : FTAG_W'(0),
                     off0 ? FTAG_W'(head0) : FTAG_W'(0),
                     off_cnt,
                     CNT_W'(ins)};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("occupancy beyond queue depth");

  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_fire |=> $stable(count_r))
    else $error("occupancy changed without an input word");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && rm == '0 && ins == '0) |=> $stable(count_r))
    else $error("occupancy changed on an idle tick");

  a_offer_bound: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (CW'(out_data_r[3:2]) <= count_r))
    else $error("offered more entries than held");

  a_ins_bound: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> (ins <= sub_n))
    else $error("inserted more tags than submitted");

endmodule
`default_nettype wire

// File: bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the multi-port instruction queue.
// ----------------------------------------------------------------------------
// Ticks come from a pending queue. A driver feeds them in with random gaps.
// A receiver takes results with random stalls. Each accepted tick runs
// through a behavioral copy of the queue: the copy drops, inserts and
// offers entries. The resulting word is held until the monitor compares it,
// field by field, with the block's output. Phases cover every
// leave threshold setting, a long receiver hold and full-queue refusals.
// ----------------------------------------------------------------------------
module tb;
  import miq_pkg::*;

  localparam int Q_DEPTH = 8;
  localparam int IN_LANES = 2;
  localparam int OUT_LANES = 2;

  typedef struct packed {
    logic [2*STATE_W-1:0] states;
    logic [FTAG_W-1:0]    tag1;
    logic [FTAG_W-1:0]    tag0;
    logic [CNT_W-1:0]     sub;
    logic [CNT_W-1:0]     acc;
  } tick_t;

  typedef struct packed {
    logic [OCC_W-1:0]  occ;
    logic [FTAG_W-1:0] tag1;
    logic [FTAG_W-1:0] tag0;
    logic [CNT_W-1:0]  offer;
    logic [CNT_W-1:0]  ins;
  } result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [WORD_W-1:0]  in_tdata = '0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [WORD_W-1:0]  out_tdata;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [STATE_W-1:0] cfg_data = LC_RESET;

  tick_t   tick_q[$];
  result_t expect_q[$];
  tick_t   cur_tick;
  result_t got_word;
  result_t want_word;

  logic [FTAG_W-1:0]  slot_tags[Q_DEPTH];
  int unsigned        q_head;
  int unsigned        q_count;
  logic [STATE_W-1:0] leave_min;

  int  errors;
  int  ticks_sent;
  int  words_checked;
  int  settings_used;
  int  peak_occ;
  int  full_refusals;
  int  tx_gap;
  int  rx_gap;
  bit  tx_gaps_on;
  bit  rx_gaps_on;
  bit  rx_hold;

  multi_port_instruction_queue #(
    .DEPTH_LOG2 (3),
    .SUB_PORTS  (IN_LANES),
    .OFFER_PORTS(OUT_LANES),
    .TAG_WIDTH  (32)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic result_t advance_queue(input tick_t t);
    result_t           r;
    int unsigned       take;
    int unsigned       put;
    int unsigned       room;
    logic [FTAG_W-1:0] tag;
    bit                stop;
    r = '0;
    take = t.acc;
    if (take > q_count) take = q_count;
    q_head = (q_head + take) % Q_DEPTH;
    q_count = q_count - take;
    put = (t.sub > IN_LANES) ? IN_LANES : t.sub;
    room = Q_DEPTH - q_count;
    if (put > room) begin
      full_refusals += put - room;
      put = room;
    end
    for (int i = 0; i < put; i++) begin
      slot_tags[(q_head + q_count) % Q_DEPTH] = (i == 0) ? t.tag0 : t.tag1;
      q_count++;
    end
    stop = 1'b0;
    for (int i = 0; i < OUT_LANES; i++) begin
      if (!stop) begin
        if (i < q_count && t.states[STATE_W*i +: STATE_W] >= leave_min) begin
          tag = slot_tags[(q_head + i) % Q_DEPTH];
          if (i == 0) r.tag0 = tag;
          else r.tag1 = tag;
          r.offer = r.offer + 1'b1;
        end else begin
          stop = 1'b1;
        end
      end
    end
    r.ins = CNT_W'(put);
    r.occ = OCC_W'(q_count);
    if (q_count > peak_occ) peak_occ = q_count;
    return r;
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic check_field(input string name, input logic [FTAG_W-1:0] want,
                             input logic [FTAG_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endtask

  // driver: predict on accept, then load the next word or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expect_q.push_back(advance_queue(cur_tick));
        ticks_sent++;
      end
      if (!in_tvalid || in_tready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_tvalid <= 1'b0;
        end else if (tick_q.size() != 0) begin
          cur_tick = tick_q.pop_front();
          in_tdata <= cur_tick;
          in_tvalid <= 1'b1;
          if (tx_gaps_on && $urandom_range(0, 3) == 0) tx_gap = gap_len();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || rx_hold) begin
      out_tready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      out_tready <= 1'b0;
    end else if (rx_gaps_on && $urandom_range(0, 3) == 0) begin
      rx_gap = gap_len() - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_word = out_tdata;
      if (expect_q.size() == 0) begin
        $error("unexpected output word 0x%0h", out_tdata);
        errors++;
      end else begin
        want_word = expect_q.pop_front();
        check_field("inserted_count", want_word.ins, got_word.ins);
        check_field("offered_count", want_word.offer, got_word.offer);
        check_field("offered_tag_first", want_word.tag0, got_word.tag0);
        check_field("offered_tag_second", want_word.tag1, got_word.tag1);
        check_field("occupancy", want_word.occ, got_word.occ);
        words_checked++;
      end
    end
  end

  task automatic queue_tick(input int acc, input int sub, input logic [FTAG_W-1:0] t0,
                            input logic [FTAG_W-1:0] t1,
                            input logic [2*STATE_W-1:0] states);
    tick_t t;
    t.acc = CNT_W'(acc);
    t.sub = CNT_W'(sub);
    t.tag0 = t0;
    t.tag1 = t1;
    t.states = states;
    tick_q.push_back(t);
  endtask

  function automatic logic [FTAG_W-1:0] rand_tag();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  // alternate fill-heavy and drain-heavy runs so the queue hits both ends
  task automatic load_random(input int n);
    bit fill;
    int r;
    int acc;
    int sub;
    fill = 1'b1;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 24) == 0) fill = !fill;
      r = $urandom_range(0, 99);
      if (fill) acc = (r < 50) ? 0 : (r < 85) ? 1 : (r < 97) ? 2 : 3;
      else acc = (r < 15) ? 0 : (r < 35) ? 1 : (r < 90) ? 2 : 3;
      r = $urandom_range(0, 99);
      if (fill) sub = (r < 10) ? 0 : (r < 30) ? 1 : (r < 92) ? 2 : 3;
      else sub = (r < 45) ? 0 : (r < 80) ? 1 : (r < 95) ? 2 : 3;
      queue_tick(acc, sub, rand_tag(), rand_tag(), 4'($urandom_range(0, 15)));
    end
  endtask

  task automatic wait_idle();
    while (tick_q.size() != 0 || in_tvalid || expect_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_leave(input logic [STATE_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    leave_min = value;
    settings_used++;
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    #4_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    q_head = 0;
    q_count = 0;
    leave_min = LC_RESET;
    foreach (slot_tags[i]) slot_tags[i] = '0;
    errors = 0;
    ticks_sent = 0;
    words_checked = 0;
    settings_used = 1;
    peak_occ = 0;
    full_refusals = 0;
    tx_gap = 0;
    rx_gap = 0;
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
    rx_hold = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: empty removal, clipped submit, fill to full, wrap, drain
    queue_tick(3, 0, 32'h0, 32'h0, {ST_READY, ST_READY});
    queue_tick(0, 3, 32'hFFFF_FFFF, 32'h0000_0000, {ST_READY, ST_READY});
    queue_tick(0, 1, 32'h1234_5678, 32'hFFFF_FFFF, {ST_READY, ST_WAITING});
    queue_tick(0, 2, 32'h8000_0001, 32'h7FFF_FFFE, {ST_WAITING, ST_EXECUTED});
    queue_tick(0, 2, 32'hA5A5_A5A5, 32'h5A5A_5A5A, {ST_NONE, ST_NONE});
    queue_tick(0, 2, 32'hC3C3_C3C3, 32'h3C3C_3C3C, {ST_EXECUTED, ST_READY});
    queue_tick(0, 2, 32'hDEAD_0001, 32'hDEAD_0002, {ST_READY, ST_NONE});
    queue_tick(0, 3, 32'hDEAD_0003, 32'hDEAD_0004, {ST_WAITING, ST_WAITING});
    queue_tick(1, 2, 32'h0F0F_0F0F, 32'hF0F0_F0F0, {ST_READY, ST_READY});
    queue_tick(2, 3, 32'h0000_0001, 32'h8000_0000, {ST_EXECUTED, ST_EXECUTED});
    queue_tick(2, 0, 32'h0, 32'h0, {ST_NONE, ST_WAITING});
    queue_tick(3, 0, 32'h0, 32'h0, {ST_WAITING, ST_READY});
    queue_tick(2, 1, 32'hFFFF_0000, 32'h0000_FFFF, {ST_READY, ST_READY});
    queue_tick(3, 0, 32'h0, 32'h0, {ST_READY, ST_READY});
    queue_tick(0, 1, 32'h5555_5555, 32'hAAAA_AAAA, {ST_READY, ST_READY});
    queue_tick(2, 2, 32'h1357_9BDF, 32'h2468_ACE0, {ST_NONE, ST_EXECUTED});
    queue_tick(0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, {ST_WAITING, ST_WAITING});
    queue_tick(1, 0, 32'h0, 32'h0, {ST_EXECUTED, ST_NONE});
    queue_tick(1, 0, 32'h0, 32'h0, {ST_READY, ST_READY});
    queue_tick(3, 3, 32'hFEDC_BA98, 32'h7654_3210, {ST_NONE, ST_NONE});
    wait_idle();

    // long receiver hold while the sender keeps offering
    load_random(300);
    repeat (30) @(negedge clk);
    rx_hold = 1'b1;
    repeat (90) @(negedge clk);
    rx_hold = 1'b0;
    wait_idle();

    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    write_leave(ST_NONE);
    load_random(250);
    wait_idle();

    tx_gaps_on = 1'b1;
    write_leave(ST_WAITING);
    load_random(250);
    wait_idle();

    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b1;
    write_leave(ST_EXECUTED);
    load_random(250);
    wait_idle();

    tx_gaps_on = 1'b1;
    write_leave(ST_READY);
    load_random(250);
    wait_idle();

    repeat (5) @(negedge clk);
    if (expect_q.size() != 0) begin
      $error("%0d expected words never arrived", expect_q.size());
      errors++;
    end

    $display("Ran %0d ticks across %0d threshold settings, %0d words checked.",
             ticks_sent, settings_used, words_checked);
    $display("Peak occupancy %0d, %0d tags turned away by a full queue.",
             peak_occ, full_refusals);
    if (errors == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
